/* rtl/atlb_pkg.sv */
// shared types and constants of the associative translation buffer set
`default_nettype none

package atlb_pkg;

	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_WAYS_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_SCAN = 4'b0100,
		S_REPL = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
		logic scan_init;
		logic scan_step;
		logic repl;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic has_free;
		logic n_one;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/atlb_if.sv */
// request and response channel interfaces
`default_nettype none

interface atlb_req_if #(
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            opcode;
	logic [PAGE_BITS-1:0]  page_number;
	logic [FRAME_BITS-1:0] frame_number;

	modport source (output valid, output opcode, output page_number, output frame_number,
		input ready);
	modport sink (input valid, input opcode, input page_number, input frame_number,
		output ready);
endinterface

interface atlb_rsp_if #(
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [FRAME_BITS-1:0] result_frame;
	logic                  evicted_valid;
	logic [PAGE_BITS-1:0]  evicted_page;
	logic [FRAME_BITS-1:0] evicted_frame;

	modport source (output valid, output hit, output result_frame, output evicted_valid,
		output evicted_page, output evicted_frame, input ready);
	modport sink (input valid, input hit, input result_frame, input evicted_valid,
		input evicted_page, input evicted_frame, output ready);
endinterface

`default_nettype wire

/* rtl/atlb_ctrl.sv */
// sequencing state machine of the translation buffer set
`default_nettype none

module atlb_ctrl
	import atlb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.op == OP_INSERT && !sts.has_free) begin
					cmd.scan_init = 1'b1;
					state_d       = sts.n_one ? S_REPL : S_SCAN;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_REPL;
				end
			end
			S_REPL: begin
				if (sts.out_free) begin
					cmd.repl = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/atlb_dp.sv */
// entry storage, match logic, stamp scan and result register
`default_nettype none

module atlb_dp
	import atlb_pkg::*;
#(
	parameter int WAYS       = 8,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20,
	parameter int STAMP_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic [1:0]            in_opcode,
	input  wire logic [PAGE_BITS-1:0]  in_page,
	input  wire logic [FRAME_BITS-1:0] in_frame,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_hit,
	output logic [FRAME_BITS-1:0]      out_result_frame,
	output logic                       out_evicted_valid,
	output logic [PAGE_BITS-1:0]       out_evicted_page,
	output logic [FRAME_BITS-1:0]      out_evicted_frame
);

	localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW = $clog2(WAYS + 1);

	logic [CFG_W-1:0]      ways_q;
	logic [STAMP_BITS-1:0] stamp_ctr_q;
	logic [WAYS-1:0]       valid_q;
	logic [PAGE_BITS-1:0]  page_q  [WAYS];
	logic [FRAME_BITS-1:0] frame_q [WAYS];
	logic [STAMP_BITS-1:0] stamp_q [WAYS];

	op_t                   op_q;
	logic [PAGE_BITS-1:0]  pg_q;
	logic [FRAME_BITS-1:0] fr_q;
	logic [STAMP_BITS-1:0] now_q;

	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         best_idx_q;
	logic [STAMP_BITS-1:0] best_stamp_q;

	logic                  out_valid_q;

	logic [NW-1:0]   n_act;
	logic [WAYS-1:0] in_use;
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] free;
	logic [IW-1:0]   hit_idx;
	logic [IW-1:0]   free_idx;
	logic            out_free;
	logic            out_ld;

	// clamp the way count to 1..WAYS
	always_comb begin
		if (ways_q == '0) begin
			n_act = NW'(1);
		end else if (int'(ways_q) > WAYS) begin
			n_act = NW'(WAYS);
		end else begin
			n_act = NW'(ways_q);
		end
	end

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			in_use[i] = (i < int'(n_act));
			match[i]  = in_use[i] && valid_q[i] && (page_q[i] == pg_q);
			free[i]   = in_use[i] && !valid_q[i];
		end
	end

	// lowest matching way and lowest free way
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IW'(i);
			end
			if (free[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_ld   = cmd.commit || cmd.repl;

	assign sts.op        = op_q;
	assign sts.has_free  = |free;
	assign sts.n_one     = (n_act == NW'(1));
	assign sts.scan_last = ((NW'(idx_q) + NW'(1)) == n_act);
	assign sts.out_free  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q      <= CFG_WAYS_RESET;
			stamp_ctr_q <= '0;
			valid_q     <= '0;
			op_q        <= OP_NOP;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ways_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				stamp_ctr_q <= stamp_ctr_q + STAMP_BITS'(1);
				op_q        <= op_t'(in_opcode);
			end
			if (cmd.commit && op_q == OP_INSERT) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.commit && op_q == OP_DELETE && (|match)) begin
				valid_q[hit_idx] <= 1'b0;
			end
			if (cmd.repl) begin
				valid_q[best_idx_q] <= 1'b1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: latched item, entry contents, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pg_q  <= in_page;
			fr_q  <= in_frame;
			now_q <= stamp_ctr_q;
		end
		if (cmd.commit) begin
			unique case (op_q)
				OP_LOOKUP: begin
					if (|match) begin
						stamp_q[hit_idx] <= now_q;
					end
				end
				OP_INSERT: begin
					page_q[free_idx]  <= pg_q;
					frame_q[free_idx] <= fr_q;
					stamp_q[free_idx] <= now_q;
				end
				OP_DELETE, OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
		if (cmd.repl) begin
			page_q[best_idx_q]  <= pg_q;
			frame_q[best_idx_q] <= fr_q;
			stamp_q[best_idx_q] <= now_q;
		end
		if (cmd.scan_init) begin
			idx_q        <= IW'(1);
			best_idx_q   <= '0;
			best_stamp_q <= stamp_q[0];
		end
		if (cmd.scan_step) begin
			idx_q <= idx_q + IW'(1);
			if (stamp_q[idx_q] < best_stamp_q) begin
				best_idx_q   <= idx_q;
				best_stamp_q <= stamp_q[idx_q];
			end
		end
		if (cmd.repl) begin
			out_hit           <= 1'b0;
			out_result_frame  <= '0;
			out_evicted_valid <= 1'b1;
			out_evicted_page  <= page_q[best_idx_q];
			out_evicted_frame <= frame_q[best_idx_q];
		end else if (cmd.commit) begin
			out_hit           <= (|match) && (op_q == OP_LOOKUP || op_q == OP_DELETE);
			out_result_frame  <= ((|match) && op_q == OP_LOOKUP) ? frame_q[hit_idx] : '0;
			out_evicted_valid <= (|match) && op_q == OP_DELETE;
			out_evicted_page  <= ((|match) && op_q == OP_DELETE) ? page_q[hit_idx] : '0;
			out_evicted_frame <= ((|match) && op_q == OP_DELETE) ? frame_q[hit_idx] : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/assoc_tlb_set_lru.sv */
// top level of one fully associative translation buffer set with lru replacement
//
//  channel  dir  handshake          carries
//  cfg      in   cfg_we             ways_in_use (4 bits), write only
//  req      in   valid / ready      opcode, page_number, frame_number
//  rsp      out  valid / ready      hit, result_frame, evicted_valid/page/frame
//
//  lookup, delete, insert into a free way and no-op: the transfer in idle,
//  then parallel page compare and commit; the next request waits for idle
//  insert into a full set instead runs the stamp scan over the ways in use
//  (clamped to 1..WAYS), one way per cycle, to find and replace the oldest stamp
//  reset clears valid bits, stamp counter and control at once; no clearing pass
//  a result waits in the output register; a stalled rsp holds the set in its
//  commit or replace step until the register frees up
`default_nettype none

module assoc_tlb_set_lru
	import atlb_pkg::*;
#(
	parameter int WAYS       = 8,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20,
	parameter int STAMP_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	atlb_req_if.sink              req,
	atlb_rsp_if.source            rsp
);

	// command and status between the sequencer and the datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, evaluate, scan stamps, replace
	atlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry store, compare, priority pick, stamp scan, result register
	atlb_dp #(
		.WAYS       (WAYS),
		.PAGE_BITS  (PAGE_BITS),
		.FRAME_BITS (FRAME_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_opcode         (req.opcode),
		.in_page           (req.page_number),
		.in_frame          (req.frame_number),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_hit           (rsp.hit),
		.out_result_frame  (rsp.result_frame),
		.out_evicted_valid (rsp.evicted_valid),
		.out_evicted_page  (rsp.evicted_page),
		.out_evicted_frame (rsp.evicted_frame)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the lru translation buffer set: scoreboard class and drivers
`timescale 1ns / 100ps

import atlb_pkg::*;

localparam int TB_WAYS  = 8;
localparam int PAGE_W   = 20;
localparam int FRAME_W  = 20;
localparam int STAMP_W  = 32;

typedef struct packed {
	logic               hit;
	logic [FRAME_W-1:0] result_frame;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FRAME_W-1:0] evicted_frame;
} tlb_result_t;

// mirror of the set contents plus the queue of translations still owed by the block
class tlb_scoreboard;
	logic               way_valid [TB_WAYS];
	logic [PAGE_W-1:0]  way_page  [TB_WAYS];
	logic [FRAME_W-1:0] way_frame [TB_WAYS];
	logic [STAMP_W-1:0] way_stamp [TB_WAYS];
	logic [STAMP_W-1:0] use_clock;
	logic [CFG_W-1:0]   ways_cfg;
	tlb_result_t        owed_q[$];
	int                 mismatches;

	function new();
		for (int i = 0; i < TB_WAYS; i++) begin
			way_valid[i] = 1'b0;
			way_page[i]  = '0;
			way_frame[i] = '0;
			way_stamp[i] = '0;
		end
		use_clock  = '0;
		ways_cfg   = CFG_WAYS_RESET;
		mismatches = 0;
	endfunction

	function void set_ways(logic [CFG_W-1:0] v);
		ways_cfg = v;
	endfunction

	function int pending();
		return owed_q.size();
	endfunction

	// zero acts as one, anything above the set size acts as the set size
	function int active_ways();
		if (ways_cfg == 0) return 1;
		if (ways_cfg > TB_WAYS) return TB_WAYS;
		return int'(ways_cfg);
	endfunction

	function void note_request(op_t op, logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
		tlb_result_t r;
		int n;
		int match;
		int slot;
		r = '0;
		n = active_ways();
		match = -1;
		slot = -1;
		for (int i = 0; i < n; i++)
			if (match < 0 && way_valid[i] && way_page[i] == page) match = i;
		case (op)
			OP_LOOKUP: begin
				if (match >= 0) begin
					way_stamp[match] = use_clock;
					r.hit = 1'b1;
					r.result_frame = way_frame[match];
				end
			end
			OP_INSERT: begin
				for (int i = 0; i < n; i++)
					if (slot < 0 && !way_valid[i]) slot = i;
				if (slot < 0) begin
					// set full: oldest stamp goes, lowest way on ties
					slot = 0;
					for (int i = 1; i < n; i++)
						if (way_stamp[i] < way_stamp[slot]) slot = i;
					r.evicted_valid = 1'b1;
					r.evicted_page  = way_page[slot];
					r.evicted_frame = way_frame[slot];
				end
				way_valid[slot] = 1'b1;
				way_page[slot]  = page;
				way_frame[slot] = frame;
				way_stamp[slot] = use_clock;
			end
			OP_DELETE: begin
				if (match >= 0) begin
					r.hit = 1'b1;
					r.evicted_valid = 1'b1;
					r.evicted_page  = way_page[match];
					r.evicted_frame = way_frame[match];
					way_valid[match] = 1'b0;
				end
			end
			default: ;
		endcase
		use_clock = use_clock + 1'b1;
		owed_q.push_back(r);
	endfunction

	function void check_result(tlb_result_t got);
		tlb_result_t want;
		if (owed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] unexpected result hit=%b frame=%h ev=%b page=%h frame=%h",
					$time, got.hit, got.result_frame, got.evicted_valid,
					got.evicted_page, got.evicted_frame);
			return;
		end
		want = owed_q.pop_front();
		if (got.hit !== want.hit || got.result_frame !== want.result_frame ||
			got.evicted_valid !== want.evicted_valid ||
			got.evicted_page !== want.evicted_page ||
			got.evicted_frame !== want.evicted_frame) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] mismatch expected hit=%b frame=%h ev=%b page=%h frame=%h",
					$time, want.hit, want.result_frame, want.evicted_valid,
					want.evicted_page, want.evicted_frame);
				$display("[%0t]          actual   hit=%b frame=%h ev=%b page=%h frame=%h",
					$time, got.hit, got.result_frame, got.evicted_valid,
					got.evicted_page, got.evicted_frame);
			end
		end
	endfunction
endclass

module testbench;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	// phase-wide knobs for the drivers
	logic quiet;        // no gaps on either side
	logic squeeze_rsp;  // ask the response side for one long hold-off

	atlb_req_if #(.PAGE_BITS(PAGE_W), .FRAME_BITS(FRAME_W)) req_ch ();
	atlb_rsp_if #(.PAGE_BITS(PAGE_W), .FRAME_BITS(FRAME_W)) rsp_ch ();

	tlb_scoreboard sb = new();

	assoc_tlb_set_lru #(
		.WAYS      (TB_WAYS),
		.PAGE_BITS (PAGE_W),
		.FRAME_BITS(FRAME_W),
		.STAMP_BITS(STAMP_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// one request transfer; starts and ends at a falling edge
	task automatic send_req(input op_t op, input logic [PAGE_W-1:0] page,
		input logic [FRAME_W-1:0] frame);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.opcode       = op;
		req_ch.page_number  = page;
		req_ch.frame_number = frame;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		sb.note_request(op, page, frame);
		@(negedge clk);
	endtask

	// register write with the set idle
	task automatic write_ways(input logic [CFG_W-1:0] v);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_ways(v);
	endtask

	// every owed result back, then room for a full-set replacement to settle
	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// response side: random stalls plus one long hold-off on request
	initial begin : rsp_drain
		int hold;
		logic squeezed;
		hold = 0;
		squeezed = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_rsp && !squeezed) begin
				hold = 200;
				squeezed = 1'b1;
			end
			if (hold > 0) begin
				rsp_ch.ready = 1'b0;
				hold--;
			end else begin
				rsp_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	// result transfers checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result('{hit: rsp_ch.hit, result_frame: rsp_ch.result_frame,
				evicted_valid: rsp_ch.evicted_valid, evicted_page: rsp_ch.evicted_page,
				evicted_frame: rsp_ch.evicted_frame});
	end

	initial begin : stimulus
		logic [CFG_W-1:0]   ways_plan [12];
		logic [PAGE_W-1:0]  pool [10];
		logic [PAGE_W-1:0]  page;
		op_t                op;
		int                 r;
		int                 guard;
		ways_plan = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd7, 4'd9, 4'd8, 4'd3, 4'd6, 4'd5, 4'd8};

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		quiet               = 1'b0;
		squeeze_rsp         = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_NOP;
		req_ch.page_number  = '0;
		req_ch.frame_number = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part with all eight ways in use
		write_ways(4'd8);
		send_req(OP_LOOKUP, '0, '0);            // miss on an empty set
		send_req(OP_DELETE, '1, '1);            // delete miss on an empty set
		send_req(OP_NOP, '1, '1);               // unused opcode, all ones
		send_req(OP_INSERT, '0, '1);            // extremes of page and frame
		send_req(OP_INSERT, '1, '0);
		send_req(OP_LOOKUP, '0, '0);
		send_req(OP_LOOKUP, '1, '1);
		send_req(OP_INSERT, '0, 20'h12345);     // same page a second time
		send_req(OP_LOOKUP, '0, '0);            // lowest way wins
		send_req(OP_DELETE, '0, '0);            // removes the lower copy
		send_req(OP_LOOKUP, '0, '0);            // the other copy shows up
		for (int i = 0; i < 6; i++)             // fill the remaining free ways
			send_req(OP_INSERT, PAGE_W'(20'h100 + i), FRAME_W'(20'h200 + i));
		send_req(OP_INSERT, 20'h300, 20'h400);  // full set: oldest goes
		send_req(OP_LOOKUP, 20'h100, '0);       // refresh so it survives
		send_req(OP_INSERT, 20'h301, 20'h401);
		send_req(OP_INSERT, 20'h302, 20'h402);
		send_req(OP_DELETE, 20'h101, '0);
		send_req(OP_LOOKUP, 20'hABCDE, '0);
		drain();

		// random phases over a spread of associativity settings
		foreach (ways_plan[p]) begin
			write_ways(ways_plan[p]);
			quiet = (p % 4 == 2);
			if (p == 3) squeeze_rsp = 1'b1;
			for (int i = 0; i < 10; i++) pool[i] = PAGE_W'($urandom_range(0, 20'hFFFFF));
			pool[0] = '0;
			pool[1] = '1;
			for (int k = 0; k < 140; k++) begin
				r = $urandom_range(0, 99);
				if (r < 40) op = OP_LOOKUP;
				else if (r < 75) op = OP_INSERT;
				else if (r < 95) op = OP_DELETE;
				else op = OP_NOP;
				// small page pool keeps hits and evictions frequent
				if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom_range(0, 20'hFFFFF));
				else page = pool[$urandom_range(0, 9)];
				send_req(op, page, FRAME_W'($urandom_range(0, 20'hFFFFF)));
			end
			drain();
		end

		quiet = 1'b0;
		req_ch.valid = 1'b0;
		for (guard = 0; guard < 5000 && sb.pending() != 0; guard++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
